// ===== hw/rtl/svm_pkg.sv =====
// svm_pkg: shared constants, codes and a helper function of the supply voltage monitor
// used by the channel interfaces and by supply_voltage_monitor; no dependencies

package svm_pkg;

	localparam int ADC_BITS_DEF  = 12;
	localparam int FRAC_BITS_DEF = 24;

	localparam int MV_W    = 14;
	localparam int KIND_W  = 2;
	localparam int PCT_W   = 8;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 3;
	localparam int SLOPE_W = 20;
	localparam int OFFS_W  = 15;
	localparam int TICK_W  = 16;

	localparam int CAL_SHIFT = 16;
	localparam logic [MV_W-1:0] MV_MAX = 14'd16383;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USB_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_USB_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_SLOPE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd6;

	// supply classes
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BATTERY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_USB     = 2'd2;

	// charge curve
	localparam logic [MV_W-1:0] CURVE_LO_MV = 14'd3500;
	localparam logic [MV_W-1:0] CURVE_HI_MV = 14'd4190;
	localparam int CURVE_MV_W = 13;
	localparam int DIV_K      = 1000;
	localparam int REM_W      = 10;
	localparam int COEF_MAG_BITS = 21;

	localparam logic signed [PCT_W-1:0] PCT_NONE  = -8'sd1;
	localparam logic signed [PCT_W-1:0] PCT_EMPTY = 8'sd0;
	localparam logic signed [PCT_W-1:0] PCT_FULL  = 8'sd100;

	// coefficients in units of 1e-4, highest power first
	localparam logic [63:0] COEF4_E4 = 64'd28083808;
	localparam logic [63:0] COEF3_E4 = 64'd435609157;
	localparam logic [63:0] COEF2_E4 = 64'd2528485888;
	localparam logic [63:0] COEF1_E4 = 64'd6507674615;
	localparam logic [63:0] COEF0_E4 = 64'd6265325703;

	function automatic logic [63:0] coef_q(input logic [63:0] c_e4, input int frac);
		logic [63:0] ip;
		logic [63:0] fp;
		ip = c_e4 / 64'd10000;
		fp = c_e4 % 64'd10000;
		return (ip << frac) + (((fp << frac) + 64'd5000) / 64'd10000);
	endfunction

endpackage

// ===== hw/rtl/svm_sample_if.sv =====
// svm_sample_if: valid/ready channel carrying one raw converter item
// depends on svm_pkg

interface svm_sample_if #(
	parameter int ADC_BITS = svm_pkg::ADC_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

// ===== hw/rtl/svm_report_if.sv =====
// svm_report_if: valid/ready channel carrying one supply report item
// depends on svm_pkg

interface svm_report_if;
	import svm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [MV_W-1:0]          supply_mv;
	logic [KIND_W-1:0]        source_kind;
	logic                     out_of_range;
	logic signed [PCT_W-1:0]  battery_percent;

	modport source (output valid, output supply_mv, output source_kind,
		output out_of_range, output battery_percent, input ready);
	modport sink   (input valid, input supply_mv, input source_kind,
		input out_of_range, input battery_percent, output ready);
endinterface

// ===== hw/rtl/supply_voltage_monitor.sv =====
// supply_voltage_monitor: top level, calibration, averaging, classing and charge curve
// depends on svm_pkg, svm_sample_if, svm_report_if

// Each converter item gives one report item. Work is bit serial: a shift-add calibration
// multiply by the slope, then averaging and classing. On battery between 3500 and 4190 mV
// the quartic runs four Horner steps, each a shift-add multiply by the voltage and a
// restoring divide by 1000 plus one add, then a final rounding. One item is worked on at
// a time; the next is taken while the previous report still waits in the output register.

module supply_voltage_monitor #(
	parameter int ADC_BITS  = svm_pkg::ADC_BITS_DEF,
	parameter int FRAC_BITS = svm_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	svm_sample_if.sink                   samples,
	svm_report_if.source                 reports,
	input  logic                         cfg_wr_en,
	input  logic [svm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [svm_pkg::CFG_W-1:0]    cfg_data
);
	import svm_pkg::*;

	localparam int MUL_W  = SLOPE_W + ADC_BITS;
	localparam int HI_W   = MUL_W - CAL_SHIFT;
	localparam int V_BASE = (HI_W + 1 > OFFS_W) ? HI_W + 1 : OFFS_W;
	localparam int V_W    = V_BASE + 1;
	localparam int MAG_W  = FRAC_BITS + COEF_MAG_BITS;
	localparam int PROD_W = MAG_W + CURVE_MV_W;
	localparam int CNT_W  = $clog2(PROD_W + 1);
	localparam int RND_W  = MAG_W + 1;

	localparam logic [MAG_W-1:0] C4 = MAG_W'(coef_q(COEF4_E4, FRAC_BITS));
	localparam logic [MAG_W-1:0] C3 = MAG_W'(coef_q(COEF3_E4, FRAC_BITS));
	localparam logic [MAG_W-1:0] C2 = MAG_W'(coef_q(COEF2_E4, FRAC_BITS));
	localparam logic [MAG_W-1:0] C1 = MAG_W'(coef_q(COEF1_E4, FRAC_BITS));
	localparam logic [MAG_W-1:0] C0 = MAG_W'(coef_q(COEF0_E4, FRAC_BITS));
	localparam logic [RND_W-1:0] HALF = RND_W'(1) << (FRAC_BITS - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CAL  = 4'd1;
	localparam logic [3:0] ST_UPD  = 4'd2;
	localparam logic [3:0] ST_CLS  = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_ADD  = 4'd6;
	localparam logic [3:0] ST_RND  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [MV_W-1:0]          bat_min_q, bat_max_q, usb_min_q, usb_max_q;
	logic [SLOPE_W-1:0]       slope_q;
	logic [OFFS_W-1:0]        offset_q;
	logic [TICK_W-1:0]        period_q;

	logic [3:0]               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [1:0]               step_q;
	logic [TICK_W-1:0]        ticks_q;
	logic [MV_W-1:0]          avg_q;
	logic                     primed_q;

	logic [ADC_BITS-1:0]      samp_q;
	logic [MUL_W-1:0]         cal_q;
	logic                     sign_q;
	logic [MAG_W-1:0]         mag_q;
	logic [PROD_W-1:0]        prod_q;
	logic [CURVE_MV_W-1:0]    mvsh_q;
	logic [REM_W-1:0]         rem_q;

	logic [KIND_W-1:0]        kind_q;
	logic                     oor_q;
	logic signed [PCT_W-1:0]  pct_q;

	logic                     out_valid_q;
	logic [MV_W-1:0]          out_mv_q;
	logic [KIND_W-1:0]        out_kind_q;
	logic                     out_oor_q;
	logic signed [PCT_W-1:0]  out_pct_q;

	// calibration line
	logic [HI_W-1:0]          cal_hi;
	logic signed [V_W-1:0]    cal_v;
	logic [MV_W-1:0]          new_mv;
	logic [TICK_W-1:0]        ticks_inc;
	logic [MV_W:0]            avg_sum;

	always_comb begin
		cal_hi = cal_q[MUL_W-1:CAL_SHIFT];
		cal_v  = $signed({{(V_W-HI_W){1'b0}}, cal_hi})
			+ $signed({{(V_W-OFFS_W){offset_q[OFFS_W-1]}}, offset_q});
		if (cal_v[V_W-1]) begin
			new_mv = '0;
		end else if (cal_v > $signed({{(V_W-MV_W){1'b0}}, MV_MAX})) begin
			new_mv = MV_MAX;
		end else begin
			new_mv = cal_v[MV_W-1:0];
		end
		ticks_inc = ticks_q + TICK_W'(1);
		avg_sum   = {1'b0, avg_q} + {1'b0, new_mv};
	end

	// classing
	logic                     is_bat, is_usb, is_oor;

	always_comb begin
		is_bat = (avg_q >= bat_min_q) && (avg_q <= bat_max_q);
		is_usb = (avg_q >= usb_min_q) && (avg_q <= usb_max_q);
		is_oor = (avg_q < bat_min_q) || (avg_q > usb_max_q);
	end

	// restoring divide step
	logic [REM_W:0]           trial;
	logic                     trial_ge;
	logic [REM_W:0]           trial_sub;

	always_comb begin
		trial     = {rem_q, prod_q[PROD_W-1]};
		trial_ge  = trial >= (REM_W+1)'(DIV_K);
		trial_sub = trial - (REM_W+1)'(DIV_K);
	end

	// sign-magnitude add of the next coefficient
	logic [MAG_W-1:0]         quot;
	logic [MAG_W-1:0]         coef_mag;
	logic                     coef_neg;
	logic [MAG_W-1:0]         sum_mag;
	logic                     sum_sign;

	always_comb begin
		quot = prod_q[MAG_W-1:0];
		case (step_q)
			2'd0: begin
				coef_mag = C3;
				coef_neg = 1'b1;
			end
			2'd1: begin
				coef_mag = C2;
				coef_neg = 1'b0;
			end
			2'd2: begin
				coef_mag = C1;
				coef_neg = 1'b1;
			end
			default: begin
				coef_mag = C0;
				coef_neg = 1'b0;
			end
		endcase
		if (sign_q == coef_neg) begin
			sum_mag  = quot + coef_mag;
			sum_sign = sign_q;
		end else if (quot >= coef_mag) begin
			sum_mag  = quot - coef_mag;
			sum_sign = sign_q;
		end else begin
			sum_mag  = coef_mag - quot;
			sum_sign = coef_neg;
		end
	end

	// final rounding
	logic [RND_W-1:0]         rnd_sum;
	logic [RND_W-FRAC_BITS-1:0] rnd_int;

	always_comb begin
		rnd_sum = {1'b0, mag_q} + HALF;
		rnd_int = rnd_sum[RND_W-1:FRAC_BITS];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_min_q <= 14'd3000;
			bat_max_q <= 14'd4300;
			usb_min_q <= 14'd4500;
			usb_max_q <= 14'd5500;
			slope_q   <= 20'd131072;
			offset_q  <= '0;
			period_q  <= 16'd5000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BATTERY_MIN: bat_min_q <= cfg_data[MV_W-1:0];
				REG_BATTERY_MAX: bat_max_q <= cfg_data[MV_W-1:0];
				REG_USB_MIN:     usb_min_q <= cfg_data[MV_W-1:0];
				REG_USB_MAX:     usb_max_q <= cfg_data[MV_W-1:0];
				REG_CAL_SLOPE:   slope_q   <= cfg_data[SLOPE_W-1:0];
				REG_CAL_OFFSET:  offset_q  <= cfg_data[OFFS_W-1:0];
				REG_PERIOD:      period_q  <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			step_q   <= '0;
			ticks_q  <= '0;
			avg_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						cnt_q   <= '0;
						state_q <= ST_CAL;
					end
				end
				ST_CAL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ADC_BITS - 1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (!primed_q) begin
						avg_q    <= new_mv;
						ticks_q  <= '0;
						primed_q <= 1'b1;
					end else if (ticks_inc >= period_q) begin
						avg_q   <= avg_sum[MV_W:1];
						ticks_q <= '0;
					end else begin
						ticks_q <= ticks_inc;
					end
					state_q <= ST_CLS;
				end
				ST_CLS: begin
					cnt_q  <= '0;
					step_q <= '0;
					if (is_bat && (avg_q >= CURVE_LO_MV) && (avg_q <= CURVE_HI_MV)) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL: begin
					if (cnt_q == CNT_W'(CURVE_MV_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					cnt_q <= '0;
					if (step_q == 2'd3) begin
						state_q <= ST_RND;
					end else begin
						step_q  <= step_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_RND: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || reports.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				samp_q <= samples.adc_sample;
				cal_q  <= '0;
			end
			ST_CAL: begin
				cal_q  <= {cal_q[MUL_W-2:0], 1'b0}
					+ (samp_q[ADC_BITS-1] ? {{(MUL_W-SLOPE_W){1'b0}}, slope_q} : '0);
				samp_q <= {samp_q[ADC_BITS-2:0], 1'b0};
			end
			ST_CLS: begin
				oor_q  <= is_oor;
				sign_q <= 1'b0;
				mag_q  <= C4;
				prod_q <= '0;
				mvsh_q <= avg_q[CURVE_MV_W-1:0];
				if (is_bat) begin
					kind_q <= KIND_BATTERY;
					if (avg_q > CURVE_HI_MV) begin
						pct_q <= PCT_FULL;
					end else begin
						pct_q <= PCT_EMPTY;
					end
				end else begin
					kind_q <= is_usb ? KIND_USB : KIND_UNKNOWN;
					pct_q  <= PCT_NONE;
				end
			end
			ST_MUL: begin
				prod_q <= {prod_q[PROD_W-2:0], 1'b0}
					+ (mvsh_q[CURVE_MV_W-1] ? {{(PROD_W-MAG_W){1'b0}}, mag_q} : '0);
				mvsh_q <= {mvsh_q[CURVE_MV_W-2:0], 1'b0};
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q  <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
				prod_q <= {prod_q[PROD_W-2:0], trial_ge};
			end
			ST_ADD: begin
				sign_q <= sum_sign;
				mag_q  <= sum_mag;
				prod_q <= '0;
				mvsh_q <= avg_q[CURVE_MV_W-1:0];
			end
			ST_RND: begin
				if (sign_q) begin
					pct_q <= PCT_EMPTY;
				end else if (rnd_int > (RND_W-FRAC_BITS)'(PCT_FULL)) begin
					pct_q <= PCT_FULL;
				end else begin
					pct_q <= rnd_int[PCT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || reports.ready)) begin
			out_valid_q <= 1'b1;
		end else if (reports.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || reports.ready)) begin
			out_mv_q   <= avg_q;
			out_kind_q <= kind_q;
			out_oor_q  <= oor_q;
			out_pct_q  <= pct_q;
		end
	end

	assign samples.ready           = (state_q == ST_IDLE);
	assign reports.valid           = out_valid_q;
	assign reports.supply_mv       = out_mv_q;
	assign reports.source_kind     = out_kind_q;
	assign reports.out_of_range    = out_oor_q;
	assign reports.battery_percent = out_pct_q;

endmodule

// ===== sim/testbench.sv =====
// testbench for supply_voltage_monitor: directed and random converter items against
// a built-in model of calibration, averaging, supply classing and charge curve
// depends on svm_pkg, svm_sample_if, svm_report_if and the supply_voltage_monitor rtl
`timescale 1ns / 100ps

module testbench;
	import svm_pkg::*;

	localparam int FRAC_BITS       = 24;
	localparam int SAMPLE_MAX      = 4095;
	localparam int FULL_MV         = 4190;
	localparam int EMPTY_MV        = 3500;
	localparam int STEER_OFFSET_MV = 2000;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int HOLDOFF_CYCLES  = 1500;
	localparam int RANDOM_PHASES   = 13;
	localparam int PHASE_ITEMS     = 100;
	localparam longint RUN_LIMIT_NS = 64'd30_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	// quartic coefficients in units of 1e-4, highest power first
	localparam longint CURVE_A4 = 64'd28083808;
	localparam longint CURVE_A3 = 64'd435609157;
	localparam longint CURVE_A2 = 64'd2528485888;
	localparam longint CURVE_A1 = 64'd6507674615;
	localparam longint CURVE_A0 = 64'd6265325703;

	typedef struct {
		logic [MV_W-1:0]         mv;
		logic [KIND_W-1:0]       kind;
		logic                    out_of_range;
		logic signed [PCT_W-1:0] pct;
	} supply_report_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	svm_sample_if sample_ch ();
	svm_report_if report_ch ();

	supply_voltage_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.reports   (report_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model state and registers
	logic [MV_W-1:0]          bat_min_mv;
	logic [MV_W-1:0]          bat_max_mv;
	logic [MV_W-1:0]          usb_min_mv;
	logic [MV_W-1:0]          usb_max_mv;
	logic [SLOPE_W-1:0]       slope_q16;
	logic signed [OFFS_W-1:0] offset_mv;
	logic [TICK_W-1:0]        period_ms;
	logic [TICK_W-1:0]        tick_count;
	logic [MV_W-1:0]          avg_mv;
	logic                     primed;

	supply_report_t pending_reports[$];
	int mismatch_count;
	bit idle_on;
	int holdoff_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 100) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic longint coef_fixed(input longint c_e4);
		return (c_e4 * (longint'(1) <<< FRAC_BITS) + 64'sd5000) / 64'sd10000;
	endfunction

	function automatic int charge_pct(input logic [MV_W-1:0] mv);
		longint acc;
		longint v;
		v = longint'(mv);
		if (mv > FULL_MV) begin
			return 100;
		end
		if (mv < EMPTY_MV) begin
			return 0;
		end
		acc = coef_fixed(CURVE_A4);
		acc = (acc * v) / 1000 - coef_fixed(CURVE_A3);
		acc = (acc * v) / 1000 + coef_fixed(CURVE_A2);
		acc = (acc * v) / 1000 - coef_fixed(CURVE_A1);
		acc = (acc * v) / 1000 + coef_fixed(CURVE_A0);
		acc = acc + (longint'(1) <<< (FRAC_BITS - 1));
		if (acc < 0) begin
			return 0;
		end
		acc = acc >>> FRAC_BITS;
		if (acc > 100) begin
			return 100;
		end
		return int'(acc);
	endfunction

	function automatic supply_report_t predict_report(input logic [ADC_BITS_DEF-1:0] sample);
		supply_report_t r;
		longint scaled;
		longint line_mv;
		logic [MV_W-1:0] mv;
		logic [KIND_W-1:0] kind;
		scaled = longint'((64'(slope_q16) * 64'(sample)) >> CAL_SHIFT);
		line_mv = scaled + longint'(offset_mv);
		if (line_mv < 0) begin
			mv = '0;
		end else if (line_mv > longint'(MV_MAX)) begin
			mv = MV_MAX;
		end else begin
			mv = line_mv[MV_W-1:0];
		end
		if (!primed) begin
			avg_mv = mv;
			tick_count = '0;
			primed = 1'b1;
		end else begin
			tick_count = tick_count + 16'd1;
			if (tick_count >= period_ms) begin
				avg_mv = MV_W'(({1'b0, avg_mv} + {1'b0, mv}) >> 1);
				tick_count = '0;
			end
		end
		if (avg_mv >= bat_min_mv && avg_mv <= bat_max_mv) begin
			kind = KIND_BATTERY;
		end else if (avg_mv >= usb_min_mv && avg_mv <= usb_max_mv) begin
			kind = KIND_USB;
		end else begin
			kind = KIND_UNKNOWN;
		end
		r.mv = avg_mv;
		r.kind = kind;
		r.out_of_range = (avg_mv < bat_min_mv) || (avg_mv > usb_max_mv);
		r.pct = (kind == KIND_BATTERY) ? PCT_W'(charge_pct(avg_mv)) : PCT_NONE;
		return r;
	endfunction

	// entered and left at a falling edge
	task automatic send_sample(input logic [ADC_BITS_DEF-1:0] sample);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.adc_sample <= sample;
		do begin
			@(posedge clk);
		end while (!sample_ch.ready);
		pending_reports.push_back(predict_report(sample));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_BATTERY_MIN: bat_min_mv = data[MV_W-1:0];
			REG_BATTERY_MAX: bat_max_mv = data[MV_W-1:0];
			REG_USB_MIN:     usb_min_mv = data[MV_W-1:0];
			REG_USB_MAX:     usb_max_mv = data[MV_W-1:0];
			REG_CAL_SLOPE:   slope_q16 = data[SLOPE_W-1:0];
			REG_CAL_OFFSET:  offset_mv = data[OFFS_W-1:0];
			REG_PERIOD:      period_ms = data[TICK_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		sample_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_reports.size() != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		if (pending_reports.size() != 0) begin
			log_mismatch($sformatf("%0d report items never arrived", pending_reports.size()));
			pending_reports.delete();
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_thresholds(input int bmin, input int bmax, input int umin, input int umax);
		write_reg(REG_BATTERY_MIN, CFG_W'(bmin));
		write_reg(REG_BATTERY_MAX, CFG_W'(bmax));
		write_reg(REG_USB_MIN, CFG_W'(umin));
		write_reg(REG_USB_MAX, CFG_W'(umax));
	endtask

	// with 1 mv per count and a fixed offset, pick samples that land the average on a value
	task automatic steer_to(input int target_mv);
		int n;
		int tries;
		tries = 0;
		do begin
			n = 2 * target_mv - int'(avg_mv) - STEER_OFFSET_MV;
			if (n < 0) begin
				n = 0;
			end else if (n > SAMPLE_MAX) begin
				n = SAMPLE_MAX;
			end
			send_sample(ADC_BITS_DEF'(n));
			tries++;
		end while (avg_mv != target_mv && tries < 4);
	endtask

	task automatic test_first_sample_loads();
		send_sample(12'd1900);
		send_sample(12'd4095);
		send_sample(12'd0);
	endtask

	task automatic test_zero_period_boundaries();
		int targets[] = '{3499, 3500, 4190, 4191, 2999, 3000, 4300, 4301, 4500, 5500, 5501};
		wait_idle();
		write_reg(REG_CAL_SLOPE, 20'd65536);
		write_reg(REG_CAL_OFFSET, CFG_W'(STEER_OFFSET_MV));
		write_reg(REG_PERIOD, 20'd0);
		foreach (targets[i]) begin
			steer_to(targets[i]);
		end
	endtask

	task automatic test_calibration_saturation();
		wait_idle();
		write_reg(REG_CAL_SLOPE, 20'hFFFFF);
		write_reg(REG_CAL_OFFSET, 20'h03FFF);
		send_sample(12'd4095);
		wait_idle();
		write_reg(REG_CAL_SLOPE, 20'd0);
		write_reg(REG_CAL_OFFSET, 20'h04000);
		send_sample(12'd0);
		send_sample(12'd4095);
	endtask

	task automatic test_class_overlap();
		wait_idle();
		write_thresholds(3000, 6000, 4000, 5000);
		write_reg(REG_CAL_SLOPE, 20'd65536);
		write_reg(REG_CAL_OFFSET, CFG_W'(STEER_OFFSET_MV));
		steer_to(4600);
		steer_to(5200);
	endtask

	task automatic test_index_out_of_list();
		wait_idle();
		write_reg(REG_NONE, 20'hFFFFF);
		send_sample(12'd1500);
		send_sample(12'd2500);
	endtask

	task automatic test_period_extremes();
		wait_idle();
		write_thresholds(3000, 4300, 4500, 5500);
		write_reg(REG_PERIOD, 20'd65535);
		send_sample(12'd2048);
		send_sample(12'd1024);
		wait_idle();
		write_reg(REG_PERIOD, 20'd1);
		send_sample(12'd2048);
		send_sample(12'd1024);
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		idle_on = 1'b0;
		write_reg(REG_CAL_SLOPE, 20'd131072);
		write_reg(REG_CAL_OFFSET, 20'd0);
		write_reg(REG_PERIOD, 20'd2);
		holdoff_request = HOLDOFF_CYCLES;
		repeat (24) begin
			send_sample(ADC_BITS_DEF'($urandom_range(1700, 2100)));
		end
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		bit wild;
		int off;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			idle_on = ($urandom_range(0, 3) != 0);
			wild = ($urandom_range(0, 9) >= 7);
			if (wild) begin
				write_reg(REG_BATTERY_MIN, CFG_W'($urandom_range(0, 20'hFFFFF)));
				write_reg(REG_BATTERY_MAX, CFG_W'($urandom_range(0, 20'hFFFFF)));
				write_reg(REG_USB_MIN, CFG_W'($urandom_range(0, 20'hFFFFF)));
				write_reg(REG_USB_MAX, CFG_W'($urandom_range(0, 20'hFFFFF)));
				write_reg(REG_CAL_SLOPE, CFG_W'($urandom_range(0, 20'hFFFFF)));
				write_reg(REG_CAL_OFFSET, CFG_W'($urandom_range(0, 20'hFFFFF)));
				if ($urandom_range(0, 1)) begin
					write_reg(REG_PERIOD, CFG_W'($urandom_range(0, 20'hFFFFF)));
				end else begin
					write_reg(REG_PERIOD, CFG_W'($urandom_range(0, 3)));
				end
			end else begin
				write_thresholds($urandom_range(2800, 3200), $urandom_range(4100, 4400),
					$urandom_range(4400, 4600), $urandom_range(5300, 5700));
				write_reg(REG_CAL_SLOPE, CFG_W'($urandom_range(122880, 139264)));
				off = $urandom_range(0, 600) - 300;
				write_reg(REG_CAL_OFFSET, CFG_W'(off));
				if ($urandom_range(0, 4) == 0) begin
					write_reg(REG_PERIOD, CFG_W'($urandom_range(5, 50)));
				end else begin
					write_reg(REG_PERIOD, CFG_W'($urandom_range(0, 4)));
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_NONE, CFG_W'($urandom_range(0, 20'hFFFFF)));
			end
			repeat (PHASE_ITEMS) begin
				if (!wild && $urandom_range(0, 9) < 8) begin
					send_sample(ADC_BITS_DEF'($urandom_range(1650, 2200)));
				end else begin
					send_sample(ADC_BITS_DEF'($urandom_range(0, SAMPLE_MAX)));
				end
			end
		end
	endtask

	initial begin : report_checker
		supply_report_t want;
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		report_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_request > 0) begin
				hold_left = holdoff_request;
				holdoff_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				report_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				report_ch.ready <= 1'b0;
			end else begin
				report_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < 15) begin
					stall_left = pick_gap();
				end
			end
			@(posedge clk);
			if (report_ch.valid === 1'b1 && report_ch.ready === 1'b1) begin
				if (pending_reports.size() == 0) begin
					log_mismatch($sformatf("unexpected report item, supply_mv %0d",
						report_ch.supply_mv));
				end else begin
					want = pending_reports.pop_front();
					if (report_ch.supply_mv !== want.mv) begin
						log_mismatch($sformatf("supply_mv %0d, expected %0d",
							report_ch.supply_mv, want.mv));
					end
					if (report_ch.source_kind !== want.kind) begin
						log_mismatch($sformatf("source_kind %0d, expected %0d at %0d mv",
							report_ch.source_kind, want.kind, want.mv));
					end
					if (report_ch.out_of_range !== want.out_of_range) begin
						log_mismatch($sformatf("out_of_range %0b, expected %0b at %0d mv",
							report_ch.out_of_range, want.out_of_range, want.mv));
					end
					if (report_ch.battery_percent !== want.pct) begin
						log_mismatch($sformatf("battery_percent %0d, expected %0d at %0d mv",
							report_ch.battery_percent, want.pct, want.mv));
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.adc_sample = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		holdoff_request = 0;
		mismatch_count = 0;
		bat_min_mv = 14'd3000;
		bat_max_mv = 14'd4300;
		usb_min_mv = 14'd4500;
		usb_max_mv = 14'd5500;
		slope_q16 = 20'd131072;
		offset_mv = '0;
		period_ms = 16'd5000;
		tick_count = '0;
		avg_mv = '0;
		primed = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_first_sample_loads();
		test_zero_period_boundaries();
		test_calibration_saturation();
		test_class_overlap();
		test_index_out_of_list();
		test_period_extremes();
		test_output_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (40) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/svm_pkg.sv
hw/rtl/svm_sample_if.sv
hw/rtl/svm_report_if.sv
hw/rtl/supply_voltage_monitor.sv
sim/testbench.sv
